@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property while out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// check a property at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ rtl/srr_pkg.sv @@
package srr_pkg;

    localparam int SEQ_SPACE_DEF    = 8;
    localparam int WINDOW_DEF       = 4;
    localparam int PAYLOAD_BITS_DEF = 64;

    localparam int SEQ_BITS         = 3;
    localparam int PORT_PAYLOAD_W   = 64;

    localparam logic KIND_DELIVER   = 1'b0;
    localparam logic KIND_ACK       = 1'b1;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

@@ rtl/srr_cell.sv @@
module srr_cell #(
    parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  srr_pkg::t_cell_ctl      i_ctl,
    input  logic [PAYLOAD_BITS-1:0] i_data,
    input  logic                    i_next_filled,
    input  logic [PAYLOAD_BITS-1:0] i_next_payload,
    output logic                    o_filled,
    output logic [PAYLOAD_BITS-1:0] o_payload
);

    logic                    r_filled;
    logic [PAYLOAD_BITS-1:0] r_payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= 1'b0;
        end else if (i_ctl.load) begin
            r_filled <= 1'b1;
        end else if (i_ctl.shift) begin
            r_filled <= i_next_filled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_payload <= i_data;
        end else if (i_ctl.shift) begin
            r_payload <= i_next_payload;
        end
    end

    assign o_filled  = r_filled;
    assign o_payload = r_payload;

endmodule

@@ rtl/selective_repeat_receiver.sv @@
// channel | direction | handshake               | fields
// in      | input     | i_in_valid / o_in_ready | seq_num, checksum_ok, payload
// out     | output    | o_out_valid / i_out_ready | kind, delivered_payload, ack_num, last
//
// A good packet is stored into the slot chain, then releases D in-order deliveries
// (0 to WINDOW), the chain shifting once toward the head per delivery, then an ACK.
// A corrupt packet is dropped without any output.
// Synchronous active-low reset clears the window base and all slot flags.
// A stall on the output holds the drain; input is taken only between packets.
module selective_repeat_receiver #(
    parameter int SEQ_SPACE    = srr_pkg::SEQ_SPACE_DEF,
    parameter int WINDOW       = srr_pkg::WINDOW_DEF,
    parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [srr_pkg::SEQ_BITS-1:0]        i_seq_num,
    input  logic                                i_checksum_ok,
    input  logic [srr_pkg::PORT_PAYLOAD_W-1:0]  i_payload,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_kind,
    output logic [srr_pkg::PORT_PAYLOAD_W-1:0]  o_delivered_payload,
    output logic [srr_pkg::SEQ_BITS-1:0]        o_ack_num,
    output logic                                o_last
);

    localparam int BW = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                          r_state, n_state;
    logic [BW-1:0]                 r_base, n_base;
    logic [srr_pkg::SEQ_BITS-1:0]  r_seq;

    logic                          r_out_valid;
    logic                          r_out_kind;
    logic [PAYLOAD_BITS-1:0]       r_out_payload;
    logic [srr_pkg::SEQ_BITS-1:0]  r_out_ack;
    logic                          r_out_last;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_shift;
    logic                          w_emit;
    logic [srr_pkg::SEQ_BITS:0]    w_seq_mod;
    logic [BW:0]                   w_sum;
    logic [BW-1:0]                 w_offset;

    logic [WINDOW:0]               w_filled;
    logic [PAYLOAD_BITS-1:0]       w_pay [WINDOW+1];
    logic [WINDOW-1:0]             w_hit;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = (r_state == ST_DRAIN) && w_out_free;
    assign w_shift    = w_emit && w_filled[0];

    always_comb begin
        w_seq_mod = {1'b0, i_seq_num};
        for (int k = 0; k < 3; k++) begin
            if (int'(w_seq_mod) >= SEQ_SPACE) begin
                w_seq_mod = w_seq_mod - (srr_pkg::SEQ_BITS+1)'(SEQ_SPACE);
            end
        end
        w_sum = (BW+1)'(w_seq_mod) + (BW+1)'(SEQ_SPACE) - {1'b0, r_base};
        if (int'(w_sum) >= SEQ_SPACE) begin
            w_offset = BW'(w_sum - (BW+1)'(SEQ_SPACE));
        end else begin
            w_offset = BW'(w_sum);
        end
    end

    assign w_filled[WINDOW] = 1'b0;
    assign w_pay[WINDOW]    = '0;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        srr_pkg::t_cell_ctl w_ctl;

        assign w_hit[g]    = (int'(w_offset) == g) && !w_filled[g];
        assign w_ctl.load  = w_accept && i_checksum_ok && w_hit[g];
        assign w_ctl.shift = w_shift;

        srr_cell #(
            .PAYLOAD_BITS(PAYLOAD_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_data         (i_payload[PAYLOAD_BITS-1:0]),
            .i_next_filled  (w_filled[g+1]),
            .i_next_payload (w_pay[g+1]),
            .o_filled       (w_filled[g]),
            .o_payload      (w_pay[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_base  = r_base;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_checksum_ok) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_shift) begin
                    n_base = (int'(r_base) == SEQ_SPACE - 1) ? '0 : r_base + 1'b1;
                end else if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_seq <= i_seq_num;
        end
        if (w_emit) begin
            if (w_filled[0]) begin
                r_out_kind    <= srr_pkg::KIND_DELIVER;
                r_out_payload <= w_pay[0];
                r_out_ack     <= '0;
                r_out_last    <= 1'b0;
            end else begin
                r_out_kind    <= srr_pkg::KIND_ACK;
                r_out_payload <= '0;
                r_out_ack     <= r_seq;
                r_out_last    <= 1'b1;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_kind              = r_out_kind;
    assign o_delivered_payload = srr_pkg::PORT_PAYLOAD_W'(r_out_payload);
    assign o_ack_num           = r_out_ack;
    assign o_last              = r_out_last;

endmodule

@@ rtl/srr_checker.sv @@
`include "assert_macros.svh"

module srr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [srr_pkg::SEQ_BITS-1:0]        i_seq_num,
    input logic                                i_checksum_ok,
    input logic [srr_pkg::PORT_PAYLOAD_W-1:0]  i_payload,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic                                o_kind,
    input logic [srr_pkg::PORT_PAYLOAD_W-1:0]  o_delivered_payload,
    input logic [srr_pkg::SEQ_BITS-1:0]        o_ack_num,
    input logic                                o_last
);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) && $stable(o_delivered_payload) && $stable(o_ack_num) && $stable(o_last))
    `ASSERT_CLK(a_ack_last, i_clk, i_rst_n, o_out_valid |-> ((o_kind == srr_pkg::KIND_ACK) == o_last))
    `ASSERT_CLK(a_deliver_no_ack, i_clk, i_rst_n, o_out_valid && (o_kind == srr_pkg::KIND_DELIVER) |-> (o_ack_num == '0))
    `ASSERT_CLK(a_busy_after_good, i_clk, i_rst_n, i_in_valid && o_in_ready && i_checksum_ok |=> !o_in_ready)
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int SPACE   = srr_pkg::SEQ_SPACE_DEF;
    localparam int WIN     = srr_pkg::WINDOW_DEF;
    localparam int PBITS   = srr_pkg::PAYLOAD_BITS_DEF;
    localparam int PW      = srr_pkg::PORT_PAYLOAD_W;
    localparam int SW      = srr_pkg::SEQ_BITS;
    localparam logic [PW-1:0] PMASK = {PW{1'b1}} >> (PW - PBITS);
    localparam int N_RANDOM    = 500;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 60;
    localparam int DRAIN_TAIL  = 16;

    typedef struct packed {
        logic          kind;
        logic [PW-1:0] data;
        logic [SW-1:0] ack;
        logic          last;
    } t_srr_beat;

    typedef struct packed {
        logic [SW-1:0] seq;
        logic          ok;
        logic [PW-1:0] data;
        logic          pinned;
        logic          pin_dlv;
    } t_pkt_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    logic [SW-1:0] i_seq_num;
    logic          i_checksum_ok;
    logic [PW-1:0] i_payload;
    logic          o_out_valid;
    logic          i_out_ready;
    logic          o_kind;
    logic [PW-1:0] o_delivered_payload;
    logic [SW-1:0] o_ack_num;
    logic          o_last;

    logic          cur_pinned;
    logic          cur_pin_dlv;

    t_srr_beat     results_due[$];
    logic [SW-1:0] win_base;
    logic          win_full [WIN];
    logic [PW-1:0] win_data [WIN];
    int            pkts_taken;
    int            mismatches;
    int            cyc;

    t_pkt_row dir_rows [19] = '{
        '{3'd0, 1'b1, 64'h0000_0000_0000_0000, 1'b1, 1'b1},
        '{3'd1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0},
        '{3'd1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1},
        '{3'd5, 1'b1, 64'h5555_5555_5555_5555, 1'b0, 1'b0},
        '{3'd6, 1'b1, 64'h0000_0000_0000_0001, 1'b1, 1'b0},
        '{3'd4, 1'b1, 64'h8000_0000_0000_0000, 1'b0, 1'b0},
        '{3'd4, 1'b1, 64'hDEAD_BEEF_CAFE_F00D, 1'b1, 1'b0},
        '{3'd3, 1'b1, 64'h1234_5678_9ABC_DEF0, 1'b0, 1'b0},
        '{3'd2, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
        '{3'd1, 1'b1, 64'h0000_0000_0000_0001, 1'b0, 1'b0},
        '{3'd0, 1'b1, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, 1'b0},
        '{3'd7, 1'b1, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, 1'b0},
        '{3'd6, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 1'b0},
        '{3'd2, 1'b0, 64'h0000_0000_0000_0000, 1'b1, 1'b0},
        '{3'd1, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0},
        '{3'd7, 1'b1, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b0},
        '{3'd3, 1'b1, 64'h3333_3333_3333_3333, 1'b0, 1'b0},
        '{3'd2, 1'b1, 64'h2222_2222_2222_2222, 1'b0, 1'b0},
        '{3'd4, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1}
    };

    selective_repeat_receiver i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_seq_num           (i_seq_num),
        .i_checksum_ok       (i_checksum_ok),
        .i_payload           (i_payload),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_kind              (o_kind),
        .o_delivered_payload (o_delivered_payload),
        .o_ack_num           (o_ack_num),
        .o_last              (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #(20_000_000);
        $display("selective_repeat_receiver verification failed");
        $finish;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void absorb_packet(input logic [SW-1:0] seq, input logic ok,
                                          input logic [PW-1:0] data,
                                          ref t_srr_beat beats[$]);
        int        off;
        t_srr_beat b;
        off = ((int'(seq) % SPACE) + SPACE - (int'(win_base) % SPACE)) % SPACE;
        if (!ok) return;
        if (off < WIN && !win_full[off]) begin
            win_full[off] = 1'b1;
            win_data[off] = data & PMASK;
            while (win_full[0] && beats.size() < WIN) begin
                b = '{srr_pkg::KIND_DELIVER, win_data[0], '0, 1'b0};
                beats.insert(beats.size(), b);
                for (int i = 0; i + 1 < WIN; i++) begin
                    win_full[i] = win_full[i + 1];
                    win_data[i] = win_data[i + 1];
                end
                win_full[WIN - 1] = 1'b0;
                win_data[WIN - 1] = '0;
                win_base = SW'((int'(win_base) + 1) % SPACE);
            end
        end
        b = '{srr_pkg::KIND_ACK, '0, seq, 1'b1};
        beats.insert(beats.size(), b);
    endfunction

    function automatic void report(input string what, input logic [PW-1:0] want,
                                   input logic [PW-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    endfunction

    initial begin
        win_base   = '0;
        pkts_taken = 0;
        mismatches = 0;
        cyc        = 0;
        for (int i = 0; i < WIN; i++) begin
            win_full[i] = 1'b0;
            win_data[i] = '0;
        end
    end

    always @(posedge i_clk) begin
        t_srr_beat got;
        t_srr_beat want;
        t_srr_beat one;
        t_srr_beat fresh[$];
        cyc++;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_kind, o_delivered_payload, o_ack_num, o_last};
                if (results_due.size() == 0) begin
                    report("unexpected beat", '0, got.data);
                end else begin
                    want = results_due[0];
                    results_due.delete(0);
                    if (got.kind !== want.kind)
                        report("kind", PW'(want.kind), PW'(got.kind));
                    if (got.data !== want.data) report("payload", want.data, got.data);
                    if (got.ack !== want.ack)
                        report("ack_num", PW'(want.ack), PW'(got.ack));
                    if (got.last !== want.last)
                        report("last", PW'(want.last), PW'(got.last));
                end
            end
            if (i_in_valid && o_in_ready) begin
                pkts_taken++;
                fresh.delete();
                absorb_packet(i_seq_num, i_checksum_ok, i_payload, fresh);
                if (cur_pinned) begin
                    fresh.delete();
                    if (i_checksum_ok) begin
                        if (cur_pin_dlv) begin
                            one = '{srr_pkg::KIND_DELIVER, i_payload & PMASK, '0, 1'b0};
                            fresh.insert(fresh.size(), one);
                        end
                        one = '{srr_pkg::KIND_ACK, '0, i_seq_num, 1'b1};
                        fresh.insert(fresh.size(), one);
                    end
                end
                foreach (fresh[k]) results_due.insert(results_due.size(), fresh[k]);
            end
        end
    end

    initial begin
        int  stall;
        bit  held;
        held = 1'b0;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!held && pkts_taken >= HOLD_AFTER) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                stall = pick_gap(((cyc >> 9) & 3) == 2);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                i_out_ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    task automatic offer_packet(input logic [SW-1:0] seq, input logic ok,
                                input logic [PW-1:0] data, input logic pin,
                                input logic pin_dlv);
        int gap;
        gap = pick_gap(((cyc >> 9) & 3) == 1);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_seq_num     <= seq;
        i_checksum_ok <= ok;
        i_payload     <= data;
        cur_pinned    <= pin;
        cur_pin_dlv   <= pin_dlv;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    initial begin
        int            r;
        logic [SW-1:0] seq;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_seq_num     = '0;
        i_checksum_ok = 1'b0;
        i_payload     = '0;
        cur_pinned    = 1'b0;
        cur_pin_dlv   = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[n])
            offer_packet(dir_rows[n].seq, dir_rows[n].ok, dir_rows[n].data,
                         dir_rows[n].pinned, dir_rows[n].pin_dlv);

        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                seq = win_base + SW'($urandom_range(0, WIN - 1));
            else
                seq = SW'($urandom_range(0, SPACE - 1));
            offer_packet(seq, r >= 10, {$urandom, $urandom}, 1'b0, 1'b0);
        end
        i_in_valid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatches == 0)
            $display("selective_repeat_receiver verification clean");
        else
            $display("selective_repeat_receiver verification failed");
        $finish;
    end

endmodule
